FILE: rtl/arms_pkg.sv
// shared types and constants for the address region map split block
package arms_pkg;

   localparam int MAX_REGIONS = 16;
   localparam int IDX_W       = $clog2(MAX_REGIONS);
   localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
   localparam int ADDR_W      = 32;
   localparam int END_W       = ADDR_W + 1;
   localparam int ID_W        = 4;
   localparam logic [ID_W-1:0] ROOT_ID = '0;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_NOT_FOUND   = 3'd1,
      STATUS_OUTSIDE     = 3'd2,
      STATUS_SHADOWS     = 3'd3,
      STATUS_TABLE_FULL  = 3'd4
   } status_type;

   typedef enum logic {
      REQ_LOOKUP = 1'b0,
      REQ_ADD    = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_CHECK,
      ST_SHIFT,
      ST_WR_A,
      ST_WR_B,
      ST_WR_C,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [END_W-1:0]  stop;
      logic [ID_W-1:0]   owner;
      logic [ID_W-1:0]   parent;
   } entry_type;

endpackage

FILE: rtl/address_region_map_split_core.sv
// top level of the address region map split block
//
// keeps a sorted table of up to 16 non-overlapping address regions, each with
// start, exclusive end, owner id and parent id; after reset one root region
// owned by id 0 covers the whole 32-bit space. a lookup transfer (tuser 0)
// returns the region holding the address; an add transfer (tuser 1) splits the
// region holding the start address and inserts the child, or reports why not.
// one request is handled at a time: a binary search probes the table one entry
// at a time through a single table read port and comparator (at most 5 probes),
// an add then moves the later entries up one per cycle (up to 15) and writes
// the two or three new entries one per cycle. req_tready is high only while
// no request is in work; the result sits in an output register so the next
// request can be taken while it waits to be transferred.
module address_region_map_split_core
   import arms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // address[31:0], pool_size[64:32], pool_id[68:65], zero fill
   input  logic [71:0] req_tdata,
   // req_type[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0], region_index[6:3], owner_id[10:7], parent_id[14:11],
   // region_start[46:15], region_end[79:47], owner_matches[80], zero fill
   output logic [87:0] rsp_tdata
);

   // region table, one read and one write index per cycle
   entry_type                region_table [MAX_REGIONS];
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_idx;
   entry_type                wr_data;
   logic [IDX_W-1:0]         rd_idx;
   entry_type                rd_data;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         lo_ff, lo_in, hi_ff, hi_in;
   logic [CNT_W-1:0]         ptr_ff, ptr_in;
   logic [IDX_W-1:0]         p_ff, p_in;
   entry_type                par_ff, par_in;
   logic                     kind_ff, kind_in;
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic [END_W-1:0]         size_ff, size_in;
   logic [ID_W-1:0]          id_ff, id_in;
   logic [END_W-1:0]         e_ff, e_in;
   logic [1:0]               off_ff, off_in;
   logic                     same_start_ff, same_start_in;
   logic                     same_end_ff, same_end_in;
   // staged result
   status_type               res_status_ff, res_status_in;
   logic [IDX_W-1:0]         res_idx_ff, res_idx_in;
   entry_type                res_ent_ff, res_ent_in;
   logic                     res_match_ff, res_match_in;
   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [80:0]              rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]         mid;
   logic [END_W:0]           child_end;
   logic [CNT_W-1:0]         from_idx;
   logic [CNT_W:0]           count_plus;

   assign rd_data    = region_table[rd_idx];
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      ptr_in        = ptr_ff;
      p_in          = p_ff;
      par_in        = par_ff;
      kind_in       = kind_ff;
      addr_in       = addr_ff;
      size_in       = size_ff;
      id_in         = id_ff;
      e_in          = e_ff;
      off_in        = off_ff;
      same_start_in = same_start_ff;
      same_end_in   = same_end_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_ent_in    = res_ent_ff;
      res_match_in  = res_match_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_idx        = '0;
      wr_data       = par_ff;
      mid           = lo_ff + ((hi_ff - lo_ff) >> 1);
      rd_idx        = mid[IDX_W-1:0];
      child_end     = {2'b00, addr_ff} + {1'b0, size_ff};
      from_idx      = same_start_ff ? {1'b0, p_ff} : ({1'b0, p_ff} + CNT_W'(1));
      count_plus    = {1'b0, count_ff} + {{(CNT_W-1){1'b0}}, off_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser[0];
               addr_in  = req_tdata[31:0];
               size_in  = req_tdata[64:32];
               id_in    = req_tdata[68:65];
               lo_in    = '0;
               hi_in    = count_ff;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (lo_ff >= hi_ff) begin
               res_status_in = STATUS_NOT_FOUND;
               res_idx_in    = '0;
               res_ent_in    = '0;
               res_match_in  = 1'b0;
               state_in      = ST_RESP;
            end else if (addr_ff < rd_data.start) begin
               hi_in = mid;
            end else if ({1'b0, addr_ff} >= rd_data.stop) begin
               lo_in = mid + CNT_W'(1);
            end else begin
               p_in          = mid[IDX_W-1:0];
               par_in        = rd_data;
               res_idx_in    = mid[IDX_W-1:0];
               res_ent_in    = rd_data;
               res_status_in = STATUS_OK;
               res_match_in  = 1'b0;
               if (kind_ff == REQ_LOOKUP) begin
                  res_match_in = (rd_data.owner == id_ff) && (rd_data.owner != ROOT_ID);
                  state_in     = ST_RESP;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            same_start_in = (addr_ff == par_ff.start);
            same_end_in   = (child_end == {1'b0, par_ff.stop});
            off_in        = (!same_start_in && !same_end_in) ? 2'd2 : 2'd1;
            e_in          = child_end[END_W-1:0];
            ptr_in        = count_ff;
            if (child_end > {1'b0, par_ff.stop}) begin
               res_status_in = STATUS_OUTSIDE;
               state_in      = ST_RESP;
            end else if (same_start_in && same_end_in) begin
               res_status_in = STATUS_SHADOWS;
               state_in      = ST_RESP;
            end else if (({1'b0, count_ff} + {{(CNT_W-1){1'b0}}, off_in})
                         > (CNT_W+1)'(MAX_REGIONS)) begin
               res_status_in = STATUS_TABLE_FULL;
               state_in      = ST_RESP;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            // move one entry up per cycle, from the top down
            if (ptr_ff > from_idx) begin
               rd_idx  = IDX_W'(ptr_ff - CNT_W'(1));
               wr_en   = 1'b1;
               wr_idx  = IDX_W'(ptr_ff - CNT_W'(1) + {{(CNT_W-2){1'b0}}, off_ff});
               wr_data = rd_data;
               ptr_in  = ptr_ff - CNT_W'(1);
            end else begin
               state_in = ST_WR_A;
            end
         end
         ST_WR_A: begin
            wr_en = 1'b1;
            if (same_start_ff) begin
               // right remainder only
               wr_idx   = p_ff + IDX_W'(1);
               wr_data  = '{start: e_ff[ADDR_W-1:0], stop: par_ff.stop,
                            owner: par_ff.owner, parent: par_ff.parent};
               state_in = ST_WR_C;
            end else begin
               // left remainder
               wr_idx   = p_ff;
               wr_data  = '{start: par_ff.start, stop: {1'b0, addr_ff},
                            owner: par_ff.owner, parent: par_ff.parent};
               state_in = same_end_ff ? ST_WR_C : ST_WR_B;
            end
         end
         ST_WR_B: begin
            wr_en    = 1'b1;
            wr_idx   = p_ff + IDX_W'(2);
            wr_data  = '{start: e_ff[ADDR_W-1:0], stop: par_ff.stop,
                         owner: par_ff.owner, parent: par_ff.parent};
            state_in = ST_WR_C;
         end
         ST_WR_C: begin
            wr_en         = 1'b1;
            wr_idx        = same_start_ff ? p_ff : (p_ff + IDX_W'(1));
            wr_data       = '{start: addr_ff, stop: e_ff,
                              owner: id_ff, parent: par_ff.owner};
            count_in      = count_plus[CNT_W-1:0];
            res_status_in = STATUS_OK;
            res_idx_in    = wr_idx;
            res_ent_in    = wr_data;
            res_match_in  = 1'b0;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_match_ff, res_ent_ff.stop, res_ent_ff.start,
                               res_ent_ff.parent, res_ent_ff.owner, res_idx_ff,
                               res_status_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= CNT_W'(1);
         rsp_valid_ff    <= 1'b0;
         region_table[0] <= '{start: '0, stop: {1'b1, {ADDR_W{1'b0}}},
                              owner: ROOT_ID, parent: '0};
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            region_table[wr_idx] <= wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      ptr_ff        <= ptr_in;
      p_ff          <= p_in;
      par_ff        <= par_in;
      kind_ff       <= kind_in;
      addr_ff       <= addr_in;
      size_ff       <= size_in;
      id_ff         <= id_in;
      e_ff          <= e_in;
      off_ff        <= off_in;
      same_start_ff <= same_start_in;
      same_end_ff   <= same_end_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_ent_ff    <= res_ent_in;
      res_match_ff  <= res_match_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule
